/* rtl/qpr_pkg.sv */
// ----------------------------------------------------------------------------
// qpr_pkg: shared widths, codes and types of the quaternion point rotator
// Fixed-point formats, register indexes and the control group that the
// top level hands to each row unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qpr_pkg;

   localparam int QUAT_W      = 16;               // Q2.14 quaternion components
   localparam int POINT_W     = 32;               // Q16.16 coordinates
   localparam int HALF_W      = POINT_W / 2;      // point split into high and low halves
   localparam int OUT_SHIFT   = 28;               // fraction bits dropped at the output
   localparam int CSR_INDEX_W = 4;

   localparam int PROD_W      = 2 * QUAT_W;       // component product
   localparam int MAT_W       = PROD_W + 2;       // matrix entry, 2*(a-b) grows two bits
   localparam int HI_W        = MAT_W + HALF_W;   // entry times signed high half
   localparam int LO_W        = MAT_W + HALF_W + 1; // entry times unsigned low half
   localparam int HI_SUM_W    = HI_W + 2;
   localparam int LO_SUM_W    = LO_W + 2;
   localparam int TOT_W       = HI_SUM_W + HALF_W + 1;
   localparam int SHR_W       = TOT_W - OUT_SHIFT;

   // round half up: add half an output LSB before the floor shift
   localparam logic signed [LO_SUM_W-1:0] ROUND_BIAS =
      LO_SUM_W'(1) <<< (OUT_SHIFT - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUAT_W = CSR_INDEX_W'(0),
      CSR_QUAT_X = CSR_INDEX_W'(1),
      CSR_QUAT_Y = CSR_INDEX_W'(2),
      CSR_QUAT_Z = CSR_INDEX_W'(3)
   } csr_index_type;

   typedef logic signed [MAT_W-1:0]   mat_elem_type;
   typedef logic signed [POINT_W-1:0] coord_type;

   // load enables of the three stages inside a row unit
   typedef struct packed {
      logic mul_en;
      logic sum_en;
      logic out_en;
   } row_ctrl_type;

endpackage

`default_nettype wire

/* rtl/qpr_row.sv */
// ----------------------------------------------------------------------------
// qpr_row: one output coordinate of the rotation
// Dot product of one matrix row with the point over three stages:
// split multiplies, half sums, then recombine, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module qpr_row
   import qpr_pkg::*;
(
   input  wire logic         clock,
   input  wire row_ctrl_type ctrl,
   input  wire mat_elem_type mat_row [3],
   input  wire coord_type    point [3],
   output logic [POINT_W-1:0] rot
);

   logic signed [HI_W-1:0]     hi_ff [3];
   logic signed [HI_W-1:0]     hi_in [3];
   logic signed [LO_W-1:0]     lo_ff [3];
   logic signed [LO_W-1:0]     lo_in [3];
   logic signed [HI_SUM_W-1:0] hi_sum_ff;
   logic signed [HI_SUM_W-1:0] hi_sum_in;
   logic signed [LO_SUM_W-1:0] lo_sum_ff;
   logic signed [LO_SUM_W-1:0] lo_sum_in;
   logic        [POINT_W-1:0]  rot_ff;
   logic        [POINT_W-1:0]  rot_in;

   logic signed [TOT_W-1:0]    total;
   logic signed [SHR_W-1:0]    shifted;
   logic signed [HALF_W-1:0]   p_hi [3];
   logic signed [HALF_W:0]     p_lo [3];

   // stage: entry * signed high half and entry * unsigned low half
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         p_hi[j]  = $signed(point[j][POINT_W-1:HALF_W]);
         p_lo[j]  = $signed({1'b0, point[j][HALF_W-1:0]});
         hi_in[j] = HI_W'(mat_row[j]) * HI_W'(p_hi[j]);
         lo_in[j] = LO_W'(mat_row[j]) * LO_W'(p_lo[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         for (int j = 0; j < 3; j++) begin
            hi_ff[j] <= hi_in[j];
            lo_ff[j] <= lo_in[j];
         end
      end
   end

   // stage: sum the halves separately, rounding bias folded into the low sum
   always_comb begin
      hi_sum_in = HI_SUM_W'(hi_ff[0]) + HI_SUM_W'(hi_ff[1]) + HI_SUM_W'(hi_ff[2]);
      lo_sum_in = LO_SUM_W'(lo_ff[0]) + LO_SUM_W'(lo_ff[1]) + LO_SUM_W'(lo_ff[2])
                + ROUND_BIAS;
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         hi_sum_ff <= hi_sum_in;
         lo_sum_ff <= lo_sum_in;
      end
   end

   // stage: recombine, floor shift, clamp to 32 bits
   always_comb begin
      total   = (TOT_W'(hi_sum_ff) <<< HALF_W) + TOT_W'(lo_sum_ff);
      shifted = $signed(total[TOT_W-1:OUT_SHIFT]);
      if (&shifted[SHR_W-1:POINT_W-1] || !(|shifted[SHR_W-1:POINT_W-1])) begin
         rot_in = shifted[POINT_W-1:0];
      end else if (shifted[SHR_W-1]) begin
         rot_in = {1'b1, {(POINT_W-1){1'b0}}};
      end else begin
         rot_in = {1'b0, {(POINT_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_en) begin
         rot_ff <= rot_in;
      end
   end

   assign rot = rot_ff;

endmodule

`default_nettype wire

/* rtl/quaternion_point_rotator.sv */
// ----------------------------------------------------------------------------
// quaternion_point_rotator: rotates Q16.16 points by a Q2.14 quaternion
// Forms the rotation matrix of q per point and applies it, giving the
// vector part of q*p*conj(q), rounded half up and saturated.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_point_x, req_point_y, req_point_z
//  rsp      out        rsp_valid / rsp_stall  rsp_rot_x, rsp_rot_y, rsp_rot_z
//  csr      in         csr_wr_en              csr_index, csr_wr_data
//
//  One point per cycle while rsp is not stalled; rsp_valid rises once an
//  accepted point has passed the five-stage pipeline (products, matrix,
//  split multiplies, half sums, recombine and saturate).
//  Reset clears the quaternion to identity and empties the pipeline.
//  A stall on rsp holds the pipeline; empty stages still fill behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_point_rotator
   import qpr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic signed [POINT_W-1:0] req_point_x,
   input  wire logic signed [POINT_W-1:0] req_point_y,
   input  wire logic signed [POINT_W-1:0] req_point_z,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [POINT_W-1:0]   rsp_rot_x,
   output logic signed [POINT_W-1:0]   rsp_rot_y,
   output logic signed [POINT_W-1:0]   rsp_rot_z,

   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [QUAT_W-1:0]      csr_wr_data
);

   localparam int NSTAGE = 5;

   // quaternion registers
   logic signed [QUAT_W-1:0] quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;

   // stage valids and load enables
   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] en;

   // stage 1: component products and point
   logic signed [PROD_W-1:0] s1_ww_ff, s1_xx_ff, s1_yy_ff, s1_zz_ff;
   logic signed [PROD_W-1:0] s1_xy_ff, s1_xz_ff, s1_yz_ff;
   logic signed [PROD_W-1:0] s1_wx_ff, s1_wy_ff, s1_wz_ff;
   logic signed [PROD_W-1:0] s1_ww_in, s1_xx_in, s1_yy_in, s1_zz_in;
   logic signed [PROD_W-1:0] s1_xy_in, s1_xz_in, s1_yz_in;
   logic signed [PROD_W-1:0] s1_wx_in, s1_wy_in, s1_wz_in;
   coord_type s1_pt_ff [3];

   // stage 2: matrix and point
   mat_elem_type s2_mat_ff [3][3];
   mat_elem_type s2_mat_in [3][3];
   coord_type    s2_pt_ff [3];

   row_ctrl_type       row_ctrl;
   logic [POINT_W-1:0] rot [3];

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff <= QUAT_W'(16'sd16384);
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_QUAT_W: quat_w_ff <= csr_wr_data;
            CSR_QUAT_X: quat_x_ff <= csr_wr_data;
            CSR_QUAT_Y: quat_y_ff <= csr_wr_data;
            CSR_QUAT_Z: quat_z_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   always_comb begin
      en[NSTAGE-1] = !valid_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (en[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NSTAGE-1];

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      s1_ww_in = PROD_W'(quat_w_ff) * PROD_W'(quat_w_ff);
      s1_xx_in = PROD_W'(quat_x_ff) * PROD_W'(quat_x_ff);
      s1_yy_in = PROD_W'(quat_y_ff) * PROD_W'(quat_y_ff);
      s1_zz_in = PROD_W'(quat_z_ff) * PROD_W'(quat_z_ff);
      s1_xy_in = PROD_W'(quat_x_ff) * PROD_W'(quat_y_ff);
      s1_xz_in = PROD_W'(quat_x_ff) * PROD_W'(quat_z_ff);
      s1_yz_in = PROD_W'(quat_y_ff) * PROD_W'(quat_z_ff);
      s1_wx_in = PROD_W'(quat_w_ff) * PROD_W'(quat_x_ff);
      s1_wy_in = PROD_W'(quat_w_ff) * PROD_W'(quat_y_ff);
      s1_wz_in = PROD_W'(quat_w_ff) * PROD_W'(quat_z_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ww_ff <= s1_ww_in;
         s1_xx_ff <= s1_xx_in;
         s1_yy_ff <= s1_yy_in;
         s1_zz_ff <= s1_zz_in;
         s1_xy_ff <= s1_xy_in;
         s1_xz_ff <= s1_xz_in;
         s1_yz_ff <= s1_yz_in;
         s1_wx_ff <= s1_wx_in;
         s1_wy_ff <= s1_wy_in;
         s1_wz_ff <= s1_wz_in;
         s1_pt_ff[0] <= req_point_x;
         s1_pt_ff[1] <= req_point_y;
         s1_pt_ff[2] <= req_point_z;
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      s2_mat_in[0][0] = MAT_W'(s1_ww_ff) + MAT_W'(s1_xx_ff) - MAT_W'(s1_yy_ff) - MAT_W'(s1_zz_ff);
      s2_mat_in[1][1] = MAT_W'(s1_ww_ff) - MAT_W'(s1_xx_ff) + MAT_W'(s1_yy_ff) - MAT_W'(s1_zz_ff);
      s2_mat_in[2][2] = MAT_W'(s1_ww_ff) - MAT_W'(s1_xx_ff) - MAT_W'(s1_yy_ff) + MAT_W'(s1_zz_ff);
      s2_mat_in[0][1] = (MAT_W'(s1_xy_ff) - MAT_W'(s1_wz_ff)) <<< 1;
      s2_mat_in[0][2] = (MAT_W'(s1_xz_ff) + MAT_W'(s1_wy_ff)) <<< 1;
      s2_mat_in[1][0] = (MAT_W'(s1_xy_ff) + MAT_W'(s1_wz_ff)) <<< 1;
      s2_mat_in[1][2] = (MAT_W'(s1_yz_ff) - MAT_W'(s1_wx_ff)) <<< 1;
      s2_mat_in[2][0] = (MAT_W'(s1_xz_ff) - MAT_W'(s1_wy_ff)) <<< 1;
      s2_mat_in[2][1] = (MAT_W'(s1_yz_ff) + MAT_W'(s1_wx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            s2_pt_ff[i] <= s1_pt_ff[i];
            for (int j = 0; j < 3; j++) begin
               s2_mat_ff[i][j] <= s2_mat_in[i][j];
            end
         end
      end
   end

   // ---------------------------------------------------------------- stages 3 to 5
   assign row_ctrl = '{mul_en: en[2], sum_en: en[3], out_en: en[4]};

   for (genvar r = 0; r < 3; r++) begin : g_row
      qpr_row u_row (
         .clock   (clock),
         .ctrl    (row_ctrl),
         .mat_row (s2_mat_ff[r]),
         .point   (s2_pt_ff),
         .rot     (rot[r])
      );
   end

   assign rsp_rot_x = $signed(rot[0]);
   assign rsp_rot_y = $signed(rot[1]);
   assign rsp_rot_z = $signed(rot[2]);

   // ---------------------------------------------------------------- assertions
   // a result held by a stall is not dropped
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   // a stage blocked downstream keeps its transaction
   a_hold_stage1: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && !en[1]) |=> valid_ff[0])
      else $error("stage 1 transaction lost");

   // a taken result with nothing behind it leaves the output empty
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !valid_ff[NSTAGE-2]) |=> !rsp_valid)
      else $error("result repeated");

   // input stall only when the pipeline is full up to the first stage
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

`default_nettype wire

/* dv/tb_quaternion_point_rotator.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_point_rotator: self-checking bench for the point rotator
// Streams Q16.16 points through the block under several quaternions written
// over the csr port. Each point is rotated in the bench in wide integer
// arithmetic, and every response is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_quaternion_point_rotator;
   import qpr_pkg::*;

   localparam int CLOCK_PERIOD     = 8;
   localparam int RESET_CYCLES     = 8;
   localparam int SETTLE_CYCLES    = 10;      // pipeline is five deep
   localparam int DRAIN_LIMIT      = 5000;
   localparam int RUN_LIMIT_CYCLES = 200000;
   localparam int RANDOM_PHASES    = 5;
   localparam int POINTS_PER_PHASE = 100;
   localparam int REPORT_LIMIT     = 10;

   // indexes that decode to no register
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LO = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HI = CSR_INDEX_W'(15);

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   class rotation_scoreboard;
      logic signed [QUAT_W-1:0] q_w, q_x, q_y, q_z;
      point_type expected_rotations[$];
      int failures;

      function new();
         q_w = QUAT_W'(16384);
         q_x = '0;
         q_y = '0;
         q_z = '0;
         failures = 0;
      endfunction

      function void set_component(logic [CSR_INDEX_W-1:0] index, logic [QUAT_W-1:0] data);
         case (index)
            CSR_QUAT_W: q_w = data;
            CSR_QUAT_X: q_x = data;
            CSR_QUAT_Y: q_y = data;
            CSR_QUAT_Z: q_z = data;
            default: ;
         endcase
      endfunction

      // floor((acc + 2^27) / 2^28), clamped to signed 32 bits
      function coord_type round_and_clamp(logic signed [95:0] acc);
         logic signed [95:0] s;
         s = (acc + 96'sh0800_0000) >>> OUT_SHIFT;
         if (s > 96'sh7fff_ffff)
            return 32'sh7fff_ffff;
         if (s < -96'sh8000_0000)
            return 32'sh8000_0000;
         return s[31:0];
      endfunction

      // vector part of q * p * conj(q) via the (unnormalized) rotation matrix
      function point_type rotate_point(point_type p);
         logic signed [95:0] w, x, y, z, px, py, pz;
         logic signed [95:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
         point_type r;
         w = 96'(q_w);
         x = 96'(q_x);
         y = 96'(q_y);
         z = 96'(q_z);
         px = 96'(p.x);
         py = 96'(p.y);
         pz = 96'(p.z);
         m00 = w*w + x*x - y*y - z*z;
         m01 = 2 * (x*y - w*z);
         m02 = 2 * (x*z + w*y);
         m10 = 2 * (x*y + w*z);
         m11 = w*w - x*x + y*y - z*z;
         m12 = 2 * (y*z - w*x);
         m20 = 2 * (x*z - w*y);
         m21 = 2 * (y*z + w*x);
         m22 = w*w - x*x - y*y + z*z;
         r.x = round_and_clamp(m00*px + m01*py + m02*pz);
         r.y = round_and_clamp(m10*px + m11*py + m12*pz);
         r.z = round_and_clamp(m20*px + m21*py + m22*pz);
         return r;
      endfunction

      function void note_point(point_type p);
         expected_rotations.push_back(rotate_point(p));
      endfunction

      function void check_rotation(point_type got);
         point_type want;
         if (expected_rotations.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: unexpected rsp transaction (%0d, %0d, %0d)",
                        $time, got.x, got.y, got.z);
            return;
         end
         want = expected_rotations.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: rotation mismatch exp (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                        $time, want.x, want.y, want.z, got.x, got.y, got.z);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid   = 1'b0;
   logic      req_stall;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   coord_type req_point_z = '0;

   logic      rsp_valid;
   logic      rsp_stall   = 1'b0;
   coord_type rsp_rot_x;
   coord_type rsp_rot_y;
   coord_type rsp_rot_z;

   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [QUAT_W-1:0]      csr_wr_data = '0;

   bit idling = 1'b1;
   rotation_scoreboard scoreboard;

   quaternion_point_rotator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_rot_x   (rsp_rot_x),
      .rsp_rot_y   (rsp_rot_y),
      .rsp_rot_z   (rsp_rot_z),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= idling && ($urandom_range(99) < 8);
   end

   // both sides sampled with pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            scoreboard.note_point(point_type'({req_point_x, req_point_y, req_point_z}));
         if (rsp_valid && !rsp_stall)
            scoreboard.check_rotation(point_type'({rsp_rot_x, rsp_rot_y, rsp_rot_z}));
      end
   end

   task automatic send_point(input coord_type x, input coord_type y, input coord_type z);
      while (idling && ($urandom_range(99) < 8)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // drop valid and let every outstanding transaction come back
   task automatic settle_pipeline();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (scoreboard.expected_rotations.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_wr_en high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [QUAT_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      scoreboard.set_component(index, data);
   endtask

   task automatic load_quaternion(input logic [QUAT_W-1:0] w, input logic [QUAT_W-1:0] x,
                                  input logic [QUAT_W-1:0] y, input logic [QUAT_W-1:0] z);
      write_csr(CSR_QUAT_W, w);
      write_csr(CSR_QUAT_X, x);
      write_csr(CSR_QUAT_Y, y);
      write_csr(CSR_QUAT_Z, z);
      csr_wr_en <= 1'b0;
   endtask

   function automatic coord_type random_coord();
      case ($urandom_range(9))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2, 3, 4: return coord_type'(int'($urandom_range(1048576)) - 524288);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic logic [QUAT_W-1:0] random_quat_part();
      if ($urandom_range(3) == 0)
         return QUAT_W'($urandom_range(65535));
      return QUAT_W'(int'($urandom_range(32768)) - 16384);
   endfunction

   initial begin
      scoreboard = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // identity after reset
      send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
      send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'shffff_ffff);
      send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0001);
      send_point(32'sh0001_0000, 32'shfffe_8000, 32'sh1234_5678);
      settle_pipeline();

      // tiny scalar: output is the point over 2^28, exercises round half up
      load_quaternion(16'h0001, 16'h0000, 16'h0000, 16'h0000);
      send_point(32'sh0800_0000, 32'shf800_0000, 32'sh07ff_ffff);
      send_point(32'shf7ff_ffff, 32'sh1800_0000, 32'she800_0000);
      settle_pipeline();

      // most negative components: |q|^2 = 16, saturates
      load_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
      send_point(32'sh0010_0000, 32'shffe0_0000, 32'sh0000_0001);
      settle_pipeline();

      // zero quaternion
      load_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh1234_5678);
      send_point(32'shffff_ffff, 32'sh0000_0001, 32'sh0000_0000);
      settle_pipeline();

      // 90 degrees about z, then writes to unused indexes must not land
      load_quaternion(16'sd11585, 16'h0000, 16'h0000, 16'sd11585);
      write_csr(CSR_UNUSED_LO, 16'hffff);
      write_csr(CSR_UNUSED_HI, 16'h8001);
      csr_wr_en <= 1'b0;
      send_point(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000);
      send_point(32'sh0000_0000, 32'sh0001_0000, 32'sh0002_0000);
      send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
      settle_pipeline();

      // most positive components
      load_quaternion(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_point(32'sh7fff_ffff, 32'sh0000_0000, 32'sh8000_0000);
      send_point(32'sh0000_8000, 32'shffff_8000, 32'sh0000_7fff);
      send_point(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f);
      settle_pipeline();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idling = (phase != 2);
         load_quaternion(random_quat_part(), random_quat_part(),
                         random_quat_part(), random_quat_part());
         for (int n = 0; n < POINTS_PER_PHASE; n++)
            send_point(random_coord(), random_coord(), random_coord());
         settle_pipeline();
      end

      if (scoreboard.expected_rotations.size() != 0)
         $display("%0d rotations never arrived", scoreboard.expected_rotations.size());
      if (scoreboard.failures == 0 && scoreboard.expected_rotations.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_CYCLES * CLOCK_PERIOD);
      $display("timeout");
      $display("Test completed with failures");
      $finish;
   end

endmodule
